/* sv/gbn_pkg.sv */
// ----------------------------------------------------------------------------
// gbn_pkg: shared definitions for the go-back-n link controller
// Field widths, event, frame-kind and action codes, and sequence helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package gbn_pkg;

  // sequence space
  localparam int MAX_SEQ_NUM = 7;
  localparam int SEQ_MOD     = MAX_SEQ_NUM + 1;
  localparam int SEQ_W       = 3;
  localparam int REF_W       = 32;
  localparam int CMD_W       = 3;
  localparam int KIND_W      = 2;
  localparam int ACT_W       = 3;

  // link events
  localparam logic [CMD_W-1:0] CMD_NEW_PKT   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PHYS_RDY  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FRAME_RX  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DATA_TMO  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_ACK_TMO   = 3'd4;

  // received frame kinds
  localparam logic [KIND_W-1:0] KIND_DATA = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NAK  = 2'd2;

  // result actions
  localparam logic [ACT_W-1:0] ACT_SEND_DATA  = 3'd0;
  localparam logic [ACT_W-1:0] ACT_SEND_ACK   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_SEND_NAK   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_DELIVER    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_STOP_TMR   = 3'd4;
  localparam logic [ACT_W-1:0] ACT_START_ATMR = 3'd5;
  localparam logic [ACT_W-1:0] ACT_WIN_STATUS = 3'd6;

  localparam logic [SEQ_W-1:0] SEQ_MAX = SEQ_W'(MAX_SEQ_NUM);

  typedef logic [SEQ_W-1:0] seq_t;

  // one result item
  typedef struct packed {
    logic [ACT_W-1:0] action;
    seq_t             seq;
    seq_t             ack;
    logic [REF_W-1:0] ref_res;
    logic             network_enable;
    logic             last;
  } result_t;

  // increment modulo the sequence space
  function automatic seq_t seq_inc(input seq_t s);
    return (s == SEQ_MAX) ? '0 : seq_t'(s + 1'b1);
  endfunction

  // ack number: one behind the expected receive sequence
  function automatic seq_t seq_prev(input seq_t s);
    return (s == '0) ? SEQ_MAX : seq_t'(s - 1'b1);
  endfunction

  // b lies in the circular window [a, c)
  function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
    return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

endpackage

`default_nettype wire

/* sv/gbn_ifs.sv */
// ----------------------------------------------------------------------------
// gbn_ifs: valid/ready channels of the go-back-n link controller
// Event channel into the block and action channel out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface gbn_in_if;
  logic                           valid;
  logic                           ready;
  logic [gbn_pkg::CMD_W-1:0]      cmd;
  logic [gbn_pkg::REF_W-1:0]      packet_ref;
  logic                           frame_ok;
  logic [gbn_pkg::KIND_W-1:0]     frame_kind;
  logic [gbn_pkg::SEQ_W-1:0]      frame_seq;
  logic [gbn_pkg::SEQ_W-1:0]      frame_piggy_ack;
  logic [gbn_pkg::REF_W-1:0]      frame_ref;

  modport source (
    output valid, cmd, packet_ref, frame_ok, frame_kind, frame_seq, frame_piggy_ack,
           frame_ref,
    input  ready
  );
  modport sink (
    input  valid, cmd, packet_ref, frame_ok, frame_kind, frame_seq, frame_piggy_ack,
           frame_ref,
    output ready
  );
endinterface

interface gbn_out_if;
  logic                           valid;
  logic                           ready;
  logic [gbn_pkg::ACT_W-1:0]      action;
  logic [gbn_pkg::SEQ_W-1:0]      seq;
  logic [gbn_pkg::SEQ_W-1:0]      ack;
  logic [gbn_pkg::REF_W-1:0]      ref_res;
  logic                           network_enable;
  logic                           last;

  modport source (
    output valid, action, seq, ack, ref_res, network_enable, last,
    input  ready
  );
  modport sink (
    input  valid, action, seq, ack, ref_res, network_enable, last,
    output ready
  );
endinterface

`default_nettype wire

/* sv/go_back_n_link_control_core.sv */
// ----------------------------------------------------------------------------
// go_back_n_link_control_core: go-back-n data link controller
// Turns link events into send, ack, nak, deliver and timer actions, ending
// each event with a window status that gates the network layer.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake        payload
//  in_chan   in   valid / ready    cmd, packet_ref, frame_ok, frame_kind,
//                                  frame_seq, frame_piggy_ack, frame_ref
//  out_chan  out  valid / ready    action, seq, ack, ref_res, network_enable, last
//
// One event at a time: in_chan.ready is high only while the sequencer is idle.
// An event is accepted, then handled one decision step or result at a time; a
// resent frame goes through check and read, read wait and send, so a nak frame
// on a full window takes the longest. The next request is taken the cycle after
// the status is loaded; a low out_chan.ready stalls the sequencer.
// Reset clears the window counters and phys_ready, not the resend store.
// ----------------------------------------------------------------------------
`default_nettype none

module go_back_n_link_control_core (
  input  wire logic  clk,
  input  wire logic  rst_n,
  gbn_in_if.sink     in_chan,
  gbn_out_if.source  out_chan
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_NEW     = 4'd1;
  localparam logic [3:0] S_NAK     = 4'd2;
  localparam logic [3:0] S_BARE    = 4'd3;
  localparam logic [3:0] S_ACKCHK  = 4'd4;
  localparam logic [3:0] S_DELIV   = 4'd5;
  localparam logic [3:0] S_ATMR    = 4'd6;
  localparam logic [3:0] S_RS_INIT = 4'd7;
  localparam logic [3:0] S_RS_RD   = 4'd8;
  localparam logic [3:0] S_RS_WAIT = 4'd9;
  localparam logic [3:0] S_RS_EMIT = 4'd10;
  localparam logic [3:0] S_STATUS  = 4'd11;

  logic [3:0]                  state_r, state_nxt;
  gbn_pkg::seq_t               next_seq_r, next_seq_nxt;
  gbn_pkg::seq_t               oldest_r, oldest_nxt;
  gbn_pkg::seq_t               exp_rx_r, exp_rx_nxt;
  gbn_pkg::seq_t               outst_r, outst_nxt;
  gbn_pkg::seq_t               rs_cnt_r, rs_cnt_nxt;
  logic                        phys_rdy_r, phys_rdy_nxt;
  logic                        out_valid_r, out_valid_nxt;
  gbn_pkg::result_t            out_r, out_nxt;

  // latched request fields
  logic [gbn_pkg::REF_W-1:0]   ref_in_r;
  logic [gbn_pkg::KIND_W-1:0]  kind_r;
  gbn_pkg::seq_t               fseq_r;
  gbn_pkg::seq_t               fack_r;

  logic                        in_acc;
  logic                        slot_free;
  logic                        out_load;
  logic                        ram_we;
  logic                        ram_re;
  logic [gbn_pkg::REF_W-1:0]   ram_rdata;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign slot_free     = !out_valid_r || out_chan.ready;

  // resend store
  gbn_ram #(
    .WIDTH (gbn_pkg::REF_W),
    .DEPTH (gbn_pkg::SEQ_MOD)
  ) u_resend (
    .clk   (clk),
    .we    (ram_we),
    .waddr (next_seq_r),
    .wdata (ref_in_r),
    .re    (ram_re),
    .raddr (next_seq_r),
    .rdata (ram_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    next_seq_nxt = next_seq_r;
    oldest_nxt   = oldest_r;
    exp_rx_nxt   = exp_rx_r;
    outst_nxt    = outst_r;
    rs_cnt_nxt   = rs_cnt_r;
    phys_rdy_nxt = phys_rdy_r;
    out_load     = 1'b0;
    out_nxt      = '0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_chan.cmd)
            gbn_pkg::CMD_NEW_PKT: begin
              state_nxt = (outst_r < gbn_pkg::SEQ_MAX) ? S_NEW : S_STATUS;
            end
            gbn_pkg::CMD_PHYS_RDY: begin
              phys_rdy_nxt = 1'b1;
              state_nxt    = S_STATUS;
            end
            gbn_pkg::CMD_FRAME_RX: begin
              state_nxt = in_chan.frame_ok ? S_ACKCHK : S_NAK;
            end
            gbn_pkg::CMD_DATA_TMO: state_nxt = S_RS_INIT;
            gbn_pkg::CMD_ACK_TMO:  state_nxt = S_BARE;
            default:               state_nxt = S_STATUS;
          endcase
        end
      end
      // new packet: send and keep its handle
      S_NEW: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_nxt.action = gbn_pkg::ACT_SEND_DATA;
          out_nxt.seq    = next_seq_r;
          out_nxt.ack    = gbn_pkg::seq_prev(exp_rx_r);
          out_nxt.ref_res = ref_in_r;
          ram_we         = 1'b1;
          phys_rdy_nxt   = 1'b0;
          outst_nxt      = gbn_pkg::seq_t'(outst_r + 1'b1);
          next_seq_nxt   = gbn_pkg::seq_inc(next_seq_r);
          state_nxt      = S_STATUS;
        end
      end
      // bad frame
      S_NAK: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_nxt.action = gbn_pkg::ACT_SEND_NAK;
          out_nxt.ack    = gbn_pkg::seq_prev(exp_rx_r);
          phys_rdy_nxt   = 1'b0;
          state_nxt      = S_STATUS;
        end
      end
      // ack timeout: bare ack
      S_BARE: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_nxt.action = gbn_pkg::ACT_SEND_ACK;
          out_nxt.ack    = gbn_pkg::seq_prev(exp_rx_r);
          phys_rdy_nxt   = 1'b0;
          state_nxt      = S_STATUS;
        end
      end
      // retire acknowledged frames one per cycle while the output slot is free
      S_ACKCHK: begin
        if ((outst_r != '0) && gbn_pkg::in_window(oldest_r, fack_r, next_seq_r)) begin
          if (slot_free) begin
            out_load       = 1'b1;
            out_nxt.action = gbn_pkg::ACT_STOP_TMR;
            out_nxt.seq    = oldest_r;
            outst_nxt      = gbn_pkg::seq_t'(outst_r - 1'b1);
            oldest_nxt     = gbn_pkg::seq_inc(oldest_r);
          end
        end else if (kind_r == gbn_pkg::KIND_DATA) begin
          state_nxt = (fseq_r == exp_rx_r) ? S_DELIV : S_STATUS;
        end else if (kind_r == gbn_pkg::KIND_NAK) begin
          state_nxt = S_RS_INIT;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      // in-order data frame
      S_DELIV: begin
        if (slot_free) begin
          out_load        = 1'b1;
          out_nxt.action  = gbn_pkg::ACT_DELIVER;
          out_nxt.ref_res = ref_in_r;
          exp_rx_nxt      = gbn_pkg::seq_inc(exp_rx_r);
          state_nxt       = S_ATMR;
        end
      end
      S_ATMR: begin
        if (slot_free) begin
          out_load       = 1'b1;
          out_nxt.action = gbn_pkg::ACT_START_ATMR;
          state_nxt      = S_STATUS;
        end
      end
      // go back to the oldest unacked frame
      S_RS_INIT: begin
        next_seq_nxt = oldest_r;
        rs_cnt_nxt   = '0;
        state_nxt    = S_RS_RD;
      end
      S_RS_RD: begin
        if (rs_cnt_r < outst_r) begin
          ram_re    = 1'b1;
          state_nxt = S_RS_WAIT;
        end else begin
          state_nxt = S_STATUS;
        end
      end
      S_RS_WAIT: state_nxt = S_RS_EMIT;
      S_RS_EMIT: begin
        if (slot_free) begin
          out_load        = 1'b1;
          out_nxt.action  = gbn_pkg::ACT_SEND_DATA;
          out_nxt.seq     = next_seq_r;
          out_nxt.ack     = gbn_pkg::seq_prev(exp_rx_r);
          out_nxt.ref_res = ram_rdata;
          phys_rdy_nxt    = 1'b0;
          next_seq_nxt    = gbn_pkg::seq_inc(next_seq_r);
          rs_cnt_nxt      = gbn_pkg::seq_t'(rs_cnt_r + 1'b1);
          state_nxt       = S_RS_RD;
        end
      end
      // window status closes every event
      S_STATUS: begin
        if (slot_free) begin
          out_load               = 1'b1;
          out_nxt.action         = gbn_pkg::ACT_WIN_STATUS;
          out_nxt.network_enable = (outst_r < gbn_pkg::SEQ_MAX) && phys_rdy_r;
          out_nxt.last           = 1'b1;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_seq_r  <= '0;
      oldest_r    <= '0;
      exp_rx_r    <= '0;
      outst_r     <= '0;
      rs_cnt_r    <= '0;
      phys_rdy_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_seq_r  <= next_seq_nxt;
      oldest_r    <= oldest_nxt;
      exp_rx_r    <= exp_rx_nxt;
      outst_r     <= outst_nxt;
      rs_cnt_r    <= rs_cnt_nxt;
      phys_rdy_r  <= phys_rdy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ref_in_r <= (in_chan.cmd == gbn_pkg::CMD_NEW_PKT) ? in_chan.packet_ref
                                                        : in_chan.frame_ref;
      kind_r   <= in_chan.frame_kind;
      fseq_r   <= in_chan.frame_seq;
      fack_r   <= in_chan.frame_piggy_ack;
    end
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.action         = out_r.action;
  assign out_chan.seq            = out_r.seq;
  assign out_chan.ack            = out_r.ack;
  assign out_chan.ref_res        = out_r.ref_res;
  assign out_chan.network_enable = out_r.network_enable;
  assign out_chan.last           = out_r.last;

endmodule

`default_nettype wire

/* sv/gbn_ram.sv */
// ----------------------------------------------------------------------------
// gbn_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gbn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* sim/tb_go_back_n_link_control_core.sv */
// ----------------------------------------------------------------------------
// tb_go_back_n_link_control_core: testbench of the go-back-n link controller
// Sends link events over the request channel and predicts every action of
// each event: sends, acks, naks, deliveries, timer actions and the closing
// window status. Directed events cover the window limits, frame handling, timeouts
// and unknown commands. Random events follow, with sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_go_back_n_link_control_core;
  import gbn_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 40;
  localparam int RANDOM_EVENTS = 330;

  // event and frame-kind codes the package leaves unnamed
  localparam logic [CMD_W-1:0]  CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0]  CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0]  CMD_RSVD_7 = 3'd7;
  localparam logic [KIND_W-1:0] KIND_RSVD  = 2'd3;

  // receiver ready pattern, one bit per cycle
  localparam logic [7:0] READY_PATTERN = 8'b1101_0110;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [REF_W-1:0]  packet_ref;
    logic              frame_ok;
    logic [KIND_W-1:0] frame_kind;
    seq_t              frame_seq;
    seq_t              frame_piggy_ack;
    logic [REF_W-1:0]  frame_ref;
  } link_event_t;

  logic clk = 1'b0;
  logic rst_n;

  gbn_in_if  in_chan ();
  gbn_out_if out_chan ();

  go_back_n_link_control_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  // link state as the controller should hold it
  seq_t             tx_next        = '0;
  seq_t             tx_oldest      = '0;
  seq_t             rx_expected    = '0;
  int unsigned      tx_outstanding = 0;
  logic             link_ready     = 1'b0;
  logic [REF_W-1:0] retx_handles [SEQ_MOD];

  result_t pending_actions [$];

  int       fail_count  = 0;
  int       cycle_count = 0;
  bit       sender_gaps_on = 1'b0;
  int       burst_left  = 0;
  int       stall_mode  = 0;
  logic [2:0] stall_tick = '0;

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------------
  // action prediction
  // ---------------------------------------------------------------------------
  function automatic void expect_action(input logic [ACT_W-1:0] act, input seq_t s,
                                        input seq_t a, input logic [REF_W-1:0] h,
                                        input logic en, input logic lst);
    result_t r;
    r.action         = act;
    r.seq            = s;
    r.ack            = a;
    r.ref_res        = h;
    r.network_enable = en;
    r.last           = lst;
    pending_actions.push_back(r);
  endfunction

  // piggybacked ack: one behind the next frame we want
  function automatic seq_t ack_number();
    return seq_t'(rx_expected - 1'b1);
  endfunction

  function automatic void predict_send(input seq_t s, input logic [REF_W-1:0] h);
    expect_action(ACT_SEND_DATA, s, ack_number(), h, 1'b0, 1'b0);
    link_ready = 1'b0;
  endfunction

  // go back to the oldest unacked frame and send the whole window again
  function automatic void resend_window();
    int unsigned i;
    tx_next = tx_oldest;
    for (i = 0; i < tx_outstanding; i++) begin
      predict_send(tx_next, retx_handles[tx_next]);
      tx_next = seq_t'(tx_next + 1'b1);
    end
  endfunction

  function automatic void predict_link_actions(input link_event_t ev);
    int guard;
    guard = 0;
    case (ev.cmd)
      CMD_NEW_PKT: begin
        // a full window drops the packet
        if (tx_outstanding < MAX_SEQ_NUM) begin
          tx_outstanding++;
          predict_send(tx_next, ev.packet_ref);
          retx_handles[tx_next] = ev.packet_ref;
          tx_next = seq_t'(tx_next + 1'b1);
        end
      end
      CMD_PHYS_RDY: begin
        link_ready = 1'b1;
      end
      CMD_FRAME_RX: begin
        if (!ev.frame_ok) begin
          expect_action(ACT_SEND_NAK, '0, ack_number(), '0, 1'b0, 1'b0);
          link_ready = 1'b0;
        end else begin
          // retire every frame up to the piggybacked ack
          while (guard < SEQ_MOD && tx_outstanding > 0 &&
                 seq_t'(ev.frame_piggy_ack - tx_oldest) < seq_t'(tx_next - tx_oldest)) begin
            expect_action(ACT_STOP_TMR, tx_oldest, '0, '0, 1'b0, 1'b0);
            tx_outstanding--;
            tx_oldest = seq_t'(tx_oldest + 1'b1);
            guard++;
          end
          if (ev.frame_kind == KIND_DATA) begin
            if (ev.frame_seq == rx_expected) begin
              expect_action(ACT_DELIVER, '0, '0, ev.frame_ref, 1'b0, 1'b0);
              rx_expected = seq_t'(rx_expected + 1'b1);
              expect_action(ACT_START_ATMR, '0, '0, '0, 1'b0, 1'b0);
            end
          end else if (ev.frame_kind == KIND_NAK) begin
            resend_window();
          end
        end
      end
      CMD_DATA_TMO: begin
        resend_window();
      end
      CMD_ACK_TMO: begin
        expect_action(ACT_SEND_ACK, '0, ack_number(), '0, 1'b0, 1'b0);
        link_ready = 1'b0;
      end
      default: begin
      end
    endcase
    expect_action(ACT_WIN_STATUS, '0, '0, '0,
                  (tx_outstanding < MAX_SEQ_NUM) && link_ready, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  function automatic link_event_t make_event(input logic [CMD_W-1:0] c,
                                             input logic [REF_W-1:0] pref,
                                             input logic ok,
                                             input logic [KIND_W-1:0] kind,
                                             input seq_t fseq, input seq_t fack,
                                             input logic [REF_W-1:0] fref);
    link_event_t ev;
    ev.cmd             = c;
    ev.packet_ref      = pref;
    ev.frame_ok        = ok;
    ev.frame_kind      = kind;
    ev.frame_seq       = fseq;
    ev.frame_piggy_ack = fack;
    ev.frame_ref       = fref;
    return ev;
  endfunction

  // drive one request, wait for it to be taken, then predict its actions
  task automatic send_event(input link_event_t ev);
    int gap;
    @(negedge clk);
    if (sender_gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      in_chan.valid = 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_chan.cmd             = ev.cmd;
    in_chan.packet_ref      = ev.packet_ref;
    in_chan.frame_ok        = ev.frame_ok;
    in_chan.frame_kind      = ev.frame_kind;
    in_chan.frame_seq       = ev.frame_seq;
    in_chan.frame_piggy_ack = ev.frame_piggy_ack;
    in_chan.frame_ref       = ev.frame_ref;
    in_chan.valid           = 1'b1;
    do @(posedge clk); while (!in_chan.ready);
    predict_link_actions(ev);
  endtask

  // stop sending and wait for every predicted action
  task automatic idle_until_drained();
    @(negedge clk);
    in_chan.valid = 1'b0;
    while (pending_actions.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver stalls
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    stall_tick = stall_tick + 1'b1;
    case (stall_mode)
      0:       out_chan.ready = 1'b1;
      1:       out_chan.ready = READY_PATTERN[stall_tick];
      default: out_chan.ready = ($urandom_range(0, 2) != 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // action checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [REF_W-1:0] want,
                                      input logic [REF_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_actions.size() == 0) begin
        $error("unexpected action %0d with nothing predicted", out_chan.action);
        fail_count++;
      end else begin
        want = pending_actions.pop_front();
        check_field("action", REF_W'(want.action), REF_W'(out_chan.action));
        check_field("seq", REF_W'(want.seq), REF_W'(out_chan.seq));
        check_field("ack", REF_W'(want.ack), REF_W'(out_chan.ack));
        check_field("ref_res", want.ref_res, out_chan.ref_res);
        check_field("network_enable", REF_W'(want.network_enable),
                    REF_W'(out_chan.network_enable));
        check_field("last", REF_W'(want.last), REF_W'(out_chan.last));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("go_back_n_link_control_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // fill the send window, handle extremes, drop a packet on a full window
  task automatic test_send_window();
    int i;
    send_event(make_event(CMD_PHYS_RDY, '0, 1'b0, KIND_DATA, '0, '0, '0));
    send_event(make_event(CMD_NEW_PKT, '0, 1'b1, KIND_ACK, 3'd7, 3'd7, '1));
    send_event(make_event(CMD_NEW_PKT, '1, 1'b0, KIND_RSVD, '0, '0, '0));
    for (i = 0; i < 5; i++) begin
      send_event(make_event(CMD_NEW_PKT, $urandom, 1'b0, KIND_DATA, '0, '0, $urandom));
    end
    // window full: no frame goes out
    send_event(make_event(CMD_NEW_PKT, 32'hA5A5_5A5A, 1'b1, KIND_DATA, '0, '0, '0));
  endtask

  // bad frame, acks, nak resend, in-order and out-of-order data, unknown kind
  task automatic test_frame_receive();
    send_event(make_event(CMD_FRAME_RX, '0, 1'b0, KIND_NAK, 3'd7, 3'd3, '1));
    send_event(make_event(CMD_FRAME_RX, '0, 1'b1, KIND_ACK, '0, 3'd2, '0));
    send_event(make_event(CMD_FRAME_RX, '0, 1'b1, KIND_NAK, '0, 3'd2, '0));
    send_event(make_event(CMD_FRAME_RX, '0, 1'b1, KIND_DATA, 3'd0, 3'd7, '1));
    send_event(make_event(CMD_FRAME_RX, '1, 1'b1, KIND_DATA, 3'd5, 3'd0, '0));
    send_event(make_event(CMD_FRAME_RX, '0, 1'b1, KIND_RSVD, 3'd1, 3'd4, $urandom));
    send_event(make_event(CMD_FRAME_RX, '0, 1'b1, KIND_DATA, 3'd1, 3'd6, $urandom));
  endtask

  // sequence wrap, timeouts, unknown commands
  task automatic test_timeouts_and_unknown();
    send_event(make_event(CMD_NEW_PKT, $urandom, 1'b0, KIND_DATA, '0, '0, '0));
    send_event(make_event(CMD_NEW_PKT, $urandom, 1'b0, KIND_DATA, '0, '0, '0));
    send_event(make_event(CMD_DATA_TMO, '0, 1'b1, KIND_NAK, '0, '0, '0));
    send_event(make_event(CMD_ACK_TMO, '1, 1'b1, KIND_DATA, '1, '1, '1));
    send_event(make_event(CMD_PHYS_RDY, '0, 1'b0, KIND_DATA, '0, '0, '0));
    send_event(make_event(CMD_RSVD_5, '1, 1'b1, KIND_NAK, '0, '0, '0));
    send_event(make_event(CMD_RSVD_6, '0, 1'b1, KIND_DATA, '0, '0, '0));
    send_event(make_event(CMD_RSVD_7, '1, 1'b0, KIND_ACK, '0, '0, '0));
  endtask

  // random event biased toward frames that ack the window and arrive in order
  function automatic link_event_t random_link_event();
    link_event_t ev;
    int pick;
    int kind_pick;
    pick = $urandom_range(0, 99);
    if (pick < 30)      ev.cmd = CMD_NEW_PKT;
    else if (pick < 45) ev.cmd = CMD_PHYS_RDY;
    else if (pick < 80) ev.cmd = CMD_FRAME_RX;
    else if (pick < 88) ev.cmd = CMD_DATA_TMO;
    else if (pick < 95) ev.cmd = CMD_ACK_TMO;
    else                ev.cmd = CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
    case ($urandom_range(0, 15))
      0:       ev.packet_ref = '0;
      1:       ev.packet_ref = '1;
      default: ev.packet_ref = $urandom;
    endcase
    ev.frame_ok   = ($urandom_range(0, 9) != 0);
    kind_pick     = $urandom_range(0, 99);
    if (kind_pick < 45)      ev.frame_kind = KIND_DATA;
    else if (kind_pick < 75) ev.frame_kind = KIND_ACK;
    else if (kind_pick < 95) ev.frame_kind = KIND_NAK;
    else                     ev.frame_kind = KIND_RSVD;
    ev.frame_seq = ($urandom_range(0, 3) != 0) ? rx_expected : seq_t'($urandom);
    if (tx_outstanding > 0 && $urandom_range(0, 4) != 0)
      ev.frame_piggy_ack = seq_t'(tx_oldest + $urandom_range(0, tx_outstanding - 1));
    else
      ev.frame_piggy_ack = seq_t'($urandom);
    ev.frame_ref = $urandom;
    return ev;
  endfunction

  task automatic test_random_traffic(input int count);
    int i;
    for (i = 0; i < count; i++) begin
      sender_gaps_on = ((i / 60) % 2) == 1;
      stall_mode     = (i / 40) % 3;
      // let the controller drain completely once mid-run
      if (i == count / 2) idle_until_drained();
      send_event(random_link_event());
    end
  endtask

  initial begin
    rst_n                   = 1'b0;
    in_chan.valid           = 1'b0;
    in_chan.cmd             = CMD_NEW_PKT;
    in_chan.packet_ref      = '0;
    in_chan.frame_ok        = 1'b0;
    in_chan.frame_kind      = KIND_DATA;
    in_chan.frame_seq       = '0;
    in_chan.frame_piggy_ack = '0;
    in_chan.frame_ref       = '0;
    stall_mode              = 1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_send_window();
    test_frame_receive();
    test_timeouts_and_unknown();
    test_random_traffic(RANDOM_EVENTS);

    idle_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("go_back_n_link_control_core test passed");
    end else begin
      $display("go_back_n_link_control_core test failed");
    end
    $finish;
  end

endmodule

/* files.f */
sv/gbn_pkg.sv
sv/gbn_ifs.sv
sv/gbn_ram.sv
sv/go_back_n_link_control_core.sv
sim/tb_go_back_n_link_control_core.sv
